[hw/rtl/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// lkv_pkg
// shared constants and types for the lru key-value store
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CAP_W    = 5;
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_PUT    = 1'b1
    } t_kind;

    typedef struct packed {
        logic             go;
        t_kind            kind;
        logic [CAP_W-1:0] cap;
    } t_row_cmd;

endpackage

[hw/rtl/lru_key_value_store.sv]
// a lookup beat passes the input register, then the result register
// throughput: one beat per cycle unless a lookup waits on a stalled result;
// a put yields no result beat; the slot row is updated as a beat leaves the
// input register, so back-to-back beats see each other's effect
// reset (synchronous, active low) empties the store and sets capacity to 16
// at once; key and value slots are not cleared
// ----------------------------------------------------------------------------
// lru_key_value_store
// fully associative lru key-value store with valid/stall channels
// ----------------------------------------------------------------------------
module lru_key_value_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  i_write_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  o_read_value
);

    logic [lkv_pkg::CAP_W-1:0]  r_cap;
    logic                       r_in_valid;
    lkv_pkg::t_kind             r_in_kind;
    logic [lkv_pkg::KEY_W-1:0]  r_in_key;
    logic [lkv_pkg::VAL_W-1:0]  r_in_val;
    logic                       r_out_valid;
    logic                       r_out_hit;
    logic [lkv_pkg::VAL_W-1:0]  r_out_value;

    logic                       out_free;
    logic                       proc_go;
    logic                       in_take;
    logic                       res_load;
    lkv_pkg::t_row_cmd          row_cmd;
    logic                       row_hit;
    logic [lkv_pkg::VAL_W-1:0]  row_value;

    assign out_free = !r_out_valid || !i_stall;
    assign proc_go  = r_in_valid && (r_in_kind == lkv_pkg::KIND_PUT || out_free);
    assign o_stall  = !i_rst_n || (r_in_valid && !proc_go);
    assign in_take  = i_valid && !o_stall;
    assign res_load = proc_go && (r_in_kind == lkv_pkg::KIND_LOOKUP);

    assign row_cmd.go   = proc_go;
    assign row_cmd.kind = r_in_kind;
    assign row_cmd.cap  = r_cap;

    lkv_slot_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (row_cmd),
        .i_key   (r_in_key),
        .i_value (r_in_val),
        .o_hit   (row_hit),
        .o_value (row_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= lkv_pkg::CAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc_go) begin
                r_in_valid <= 1'b0;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= lkv_pkg::t_kind'(i_kind);
            r_in_key  <= i_lookup_key;
            r_in_val  <= i_write_value;
        end
        if (res_load) begin
            r_out_hit   <= row_hit;
            r_out_value <= row_value;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

endmodule

[hw/rtl/lkv_slot_row.sv]
// ----------------------------------------------------------------------------
// lkv_slot_row
// recency-ordered slot row with associative compare, move-to-front and evict
// ----------------------------------------------------------------------------
module lkv_slot_row (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkv_pkg::t_row_cmd           i_cmd,
    input  logic [lkv_pkg::KEY_W-1:0]   i_key,
    input  logic [lkv_pkg::VAL_W-1:0]   i_value,
    output logic                        o_hit,
    output logic [lkv_pkg::VAL_W-1:0]   o_value
);

    logic [lkv_pkg::KEY_W-1:0]    r_key [lkv_pkg::CAPACITY];
    logic [lkv_pkg::KEY_W-1:0]    n_key [lkv_pkg::CAPACITY];
    logic [lkv_pkg::VAL_W-1:0]    r_val [lkv_pkg::CAPACITY];
    logic [lkv_pkg::VAL_W-1:0]    n_val [lkv_pkg::CAPACITY];
    logic [lkv_pkg::OCC_W-1:0]    r_occ;
    logic [lkv_pkg::OCC_W-1:0]    n_occ;

    logic [lkv_pkg::CAPACITY-1:0] match;
    logic [lkv_pkg::CAPACITY-1:0] suffix;
    logic                         hit;
    logic [lkv_pkg::VAL_W-1:0]    hit_val;
    logic [lkv_pkg::OCC_W-1:0]    eff_cap;
    logic [lkv_pkg::OCC_W-1:0]    occ_trim;

    // associative compare over the valid prefix
    always_comb begin
        hit_val = '0;
        for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
            match[i] = (lkv_pkg::OCC_W'(i) < r_occ) && (r_key[i] == i_key);
            hit_val  = hit_val | (r_val[i] & {lkv_pkg::VAL_W{match[i]}});
        end
        hit = |match;
        for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
            suffix[i] = |(match >> i);
        end
    end

    // capacity clamp and trim before insert
    always_comb begin
        if (i_cmd.cap == '0) begin
            eff_cap = lkv_pkg::OCC_W'(1);
        end else if (int'(i_cmd.cap) > lkv_pkg::CAPACITY) begin
            eff_cap = lkv_pkg::OCC_W'(lkv_pkg::CAPACITY);
        end else begin
            eff_cap = lkv_pkg::OCC_W'(i_cmd.cap);
        end
        if (r_occ >= eff_cap) begin
            occ_trim = eff_cap - lkv_pkg::OCC_W'(1);
        end else begin
            occ_trim = r_occ;
        end
    end

    always_comb begin
        n_key = r_key;
        n_val = r_val;
        n_occ = r_occ;
        if (i_cmd.go && (i_cmd.kind == lkv_pkg::KIND_PUT || hit)) begin
            // hit: shift slots up to the hit slot; new key: shift the whole row
            for (int i = 1; i < lkv_pkg::CAPACITY; i++) begin
                if (!hit || suffix[i]) begin
                    n_key[i] = r_key[i-1];
                    n_val[i] = r_val[i-1];
                end
            end
            n_key[0] = i_key;
            n_val[0] = (i_cmd.kind == lkv_pkg::KIND_PUT) ? i_value : hit_val;
            if (!hit) begin
                n_occ = occ_trim + lkv_pkg::OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_hit   = hit;
    assign o_value = hit_val;

endmodule

[hw/rtl/lkv_checker.sv]
// ----------------------------------------------------------------------------
// lkv_checker
// port-level checks for the lru key-value store, bound to the top level
// ----------------------------------------------------------------------------
module lkv_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic                              i_kind,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  i_write_value,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic                              o_hit,
    input  logic signed [lkv_pkg::VAL_W-1:0]  o_read_value
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_read_value))
        else $error("result beat changed while stalled");

    // a miss reads as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_read_value == '0)
        else $error("miss with non-zero value");

    // nothing pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat after reset");

    // a new result beat follows a lookup beat taken at the input
    a_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |->
            $past(i_valid && !o_stall && (i_kind == lkv_pkg::KIND_LOOKUP), 2))
        else $error("result beat without a lookup beat");

    // no input beat is taken in reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |-> o_stall)
        else $error("input open during reset");

endmodule

bind lru_key_value_store lkv_checker u_lkv_checker (.*);
